>>> rtl/rss_pkg.sv
`default_nettype none

package rss_pkg;

   // Block dimensions
   localparam int QUERY_MAX      = 16;
   localparam int HIT_CAP        = 256;
   localparam int NAME_LIMIT     = 127;
   localparam int CATEGORY_COUNT = 4;

   // Field widths
   localparam int MODE_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int CAT_W    = 2;
   localparam int NUM_W    = 16;
   localparam int SLOT_W   = 8;
   localparam int SHOWN_W  = 9;
   localparam int TOTAL_W  = 16;
   localparam int QLEN_W   = 5;
   localparam int POS_W    = 8;
   localparam int ENTRY_W  = CAT_W + NUM_W;
   localparam int QUERY_W  = 128;

   // Configuration port
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 64;

   // Hit list sizing
   localparam int CNT_W    = $clog2(HIT_CAP + 1);
   localparam int ADDR_W   = (HIT_CAP > 1) ? $clog2(HIT_CAP) : 1;
   localparam int CMP_W    = (((CNT_W + 1) > SLOT_W) ? (CNT_W + 1) : SLOT_W) + 1;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Transaction modes
   localparam logic [MODE_W-1:0] MODE_NAME   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_KEY    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FINISH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   // Register indexes (paddr[4:3])
   localparam logic [1:0] REG_QUERY_LOW    = 2'd0;
   localparam logic [1:0] REG_QUERY_HIGH   = 2'd1;
   localparam logic [1:0] REG_QUERY_LENGTH = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic exec;
      logic load_out;
   } rss_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              out_free;
   } rss_status_type;

endpackage

`default_nettype wire

>>> rtl/rss_ctrl.sv
`default_nettype none

module rss_ctrl
   import rss_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire rss_status_type status,
   output rss_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence one transaction: take, execute, then respond if it has a result
   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd.take     = 1'b0;
      cmd.exec     = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.mode == MODE_FINISH || status.mode == MODE_READ) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rss_datapath.sv
`default_nettype none

module rss_datapath
   import rss_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rss_cmd_type        cmd,
   output rss_status_type          status,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic [BYTE_W-1:0]  req_text_byte,
   input  wire logic [CAT_W-1:0]   req_entry_category,
   input  wire logic [NUM_W-1:0]   req_entry_number,
   input  wire logic [SLOT_W-1:0]  req_read_slot,
   input  wire logic [QUERY_W-1:0] query_bytes,
   input  wire logic [QLEN_W-1:0]  query_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_is_hit,
   output logic                    rsp_is_prefix_rank,
   output logic                    rsp_slot_valid,
   output logic [CAT_W-1:0]        rsp_hit_category,
   output logic [NUM_W-1:0]        rsp_hit_number,
   output logic [SHOWN_W-1:0]      rsp_shown_count,
   output logic [TOTAL_W-1:0]      rsp_total_hits
);

   // Latched transaction
   logic [MODE_W-1:0] mode_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [CAT_W-1:0]  cat_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [SLOT_W-1:0] slot_ff;

   // Entry scan state
   logic [BYTE_W-1:0] recent_ff [QUERY_MAX];
   logic [BYTE_W-1:0] recent_in [QUERY_MAX];
   logic [POS_W-1:0]  name_pos_ff, name_pos_in;
   logic [POS_W-1:0]  key_pos_ff, key_pos_in;
   logic              found_ff, found_in;
   logic              at_start_ff, at_start_in;
   logic              key_start_ff, key_start_in;
   logic              key_broken_ff, key_broken_in;

   // Hit lists and counters
   logic [ENTRY_W-1:0] prefix_mem    [HIT_CAP];
   logic [ENTRY_W-1:0] substring_mem [HIT_CAP];
   logic [CNT_W-1:0]   pcount_ff, pcount_in;
   logic [CNT_W-1:0]   scount_ff, scount_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // Finish and read results awaiting the output register
   logic               fin_hit_ff, fin_pre_ff;
   logic               rd_valid_ff, rd_pre_ff;
   logic [ENTRY_W-1:0] pre_rd_ff, sub_rd_ff;
   logic               rsp_valid_ff;

   logic [QLEN_W-1:0]  qlen;
   logic [BYTE_W-1:0]  win_next [QUERY_MAX];
   logic               window_same;
   logic [QLEN_W-1:0]  qidx;
   logic [BYTE_W-1:0]  key_char;
   logic               hit, pre;
   logic [ENTRY_W-1:0] entry;
   logic               do_finish, do_read;
   logic [CMP_W-1:0]   sum_w, shown_w, slot_w, pcount_w, diff_w;
   logic               slot_ok, slot_in_pre;
   logic [ENTRY_W-1:0] rd_entry;

   // Clamp the query length
   assign qlen = (query_length > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX) : query_length;

   // Latch the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mode_ff <= req_mode;
         byte_ff <= req_text_byte;
         cat_ff  <= req_entry_category;
         num_ff  <= req_entry_number;
         slot_ff <= req_read_slot;
      end
   end

   // Shift the new name byte into the window, newest at the top
   always_comb begin
      for (int i = 0; i < QUERY_MAX - 1; i++) begin
         win_next[i] = recent_ff[i + 1];
      end
      win_next[QUERY_MAX-1] = byte_ff;
   end

   // Compare the newest bytes of the window with the query, one lane per age
   always_comb begin
      window_same = 1'b1;
      for (int a = 0; a < QUERY_MAX; a++) begin
         qidx = qlen - QLEN_W'(a) - QLEN_W'(1);
         if (QLEN_W'(a) < qlen) begin
            if (win_next[QUERY_MAX-1-a] != query_bytes[{qidx[3:0], 3'b000} +: BYTE_W]) begin
               window_same = 1'b0;
            end
         end
      end
   end

   assign key_char = query_bytes[{key_pos_ff[3:0], 3'b000} +: BYTE_W];

   // Rank the finished entry
   assign hit   = (qlen != '0) && found_ff &&
                  ({1'b0, cat_ff} < (CAT_W + 1)'(CATEGORY_COUNT));
   assign pre   = hit && (at_start_ff || key_start_ff);
   assign entry = {cat_ff, num_ff};

   assign do_finish = cmd.exec && (mode_ff == MODE_FINISH);
   assign do_read   = cmd.exec && (mode_ff == MODE_READ);

   // Merged list view
   assign pcount_w    = CMP_W'(pcount_ff);
   assign sum_w       = pcount_w + CMP_W'(scount_ff);
   assign shown_w     = (sum_w > CMP_W'(HIT_CAP)) ? CMP_W'(HIT_CAP) : sum_w;
   assign slot_w      = CMP_W'(slot_ff);
   assign slot_ok     = slot_w < shown_w;
   assign slot_in_pre = slot_w < pcount_w;
   assign diff_w      = slot_w - pcount_w;

   // Next scan and list state
   always_comb begin
      recent_in     = recent_ff;
      name_pos_in   = name_pos_ff;
      key_pos_in    = key_pos_ff;
      found_in      = found_ff;
      at_start_in   = at_start_ff;
      key_start_in  = key_start_ff;
      key_broken_in = key_broken_ff;
      pcount_in     = pcount_ff;
      scount_in     = scount_ff;
      total_in      = total_ff;
      if (cmd.exec) begin
         case (mode_ff) inside
            MODE_NAME: begin
               if (name_pos_ff < POS_W'(NAME_LIMIT)) begin
                  recent_in   = win_next;
                  name_pos_in = name_pos_ff + POS_W'(1);
                  if (qlen != '0 && name_pos_in >= POS_W'(qlen) && window_same) begin
                     found_in = 1'b1;
                     if (name_pos_in == POS_W'(qlen)) begin
                        at_start_in = 1'b1;
                     end
                  end
               end
            end
            MODE_KEY: begin
               if (key_pos_ff < POS_W'(NAME_LIMIT)) begin
                  if (key_pos_ff < POS_W'(qlen) && !key_broken_ff) begin
                     if (byte_ff != key_char) begin
                        key_broken_in = 1'b1;
                     end else if (key_pos_ff + POS_W'(1) == POS_W'(qlen)) begin
                        key_start_in = 1'b1;
                     end
                  end
                  key_pos_in = key_pos_ff + POS_W'(1);
               end
            end
            MODE_FINISH, MODE_CLEAR: begin
               for (int i = 0; i < QUERY_MAX; i++) begin
                  recent_in[i] = '0;
               end
               name_pos_in   = '0;
               key_pos_in    = '0;
               found_in      = 1'b0;
               at_start_in   = 1'b0;
               key_start_in  = 1'b0;
               key_broken_in = 1'b0;
               if (mode_ff == MODE_CLEAR) begin
                  pcount_in = '0;
                  scount_in = '0;
                  total_in  = '0;
               end else if (hit) begin
                  if (total_ff != TOTAL_MAX) begin
                     total_in = total_ff + TOTAL_W'(1);
                  end
                  if (pre) begin
                     if (pcount_ff < CNT_W'(HIT_CAP)) begin
                        pcount_in = pcount_ff + CNT_W'(1);
                     end
                  end else if (scount_ff < CNT_W'(HIT_CAP)) begin
                     scount_in = scount_ff + CNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUERY_MAX; i++) begin
            recent_ff[i] <= '0;
         end
         name_pos_ff   <= '0;
         key_pos_ff    <= '0;
         found_ff      <= 1'b0;
         at_start_ff   <= 1'b0;
         key_start_ff  <= 1'b0;
         key_broken_ff <= 1'b0;
         pcount_ff     <= '0;
         scount_ff     <= '0;
         total_ff      <= '0;
      end else begin
         recent_ff     <= recent_in;
         name_pos_ff   <= name_pos_in;
         key_pos_ff    <= key_pos_in;
         found_ff      <= found_in;
         at_start_ff   <= at_start_in;
         key_start_ff  <= key_start_in;
         key_broken_ff <= key_broken_in;
         pcount_ff     <= pcount_in;
         scount_ff     <= scount_in;
         total_ff      <= total_in;
      end
   end

   // Append a hit to its list; read both lists for a slot request
   always_ff @(posedge clock) begin
      if (do_finish && hit && pre && pcount_ff < CNT_W'(HIT_CAP)) begin
         prefix_mem[pcount_ff[ADDR_W-1:0]] <= entry;
      end
      if (do_finish && hit && !pre && scount_ff < CNT_W'(HIT_CAP)) begin
         substring_mem[scount_ff[ADDR_W-1:0]] <= entry;
      end
      if (do_read) begin
         pre_rd_ff <= prefix_mem[slot_w[ADDR_W-1:0]];
         sub_rd_ff <= substring_mem[diff_w[ADDR_W-1:0]];
      end
   end

   // Hold the outcome until the output register is free
   always_ff @(posedge clock) begin
      if (do_finish) begin
         fin_hit_ff <= hit;
         fin_pre_ff <= pre;
      end
      if (do_read) begin
         rd_valid_ff <= slot_ok;
         rd_pre_ff   <= slot_in_pre;
      end
   end

   assign rd_entry = rd_valid_ff ? (rd_pre_ff ? pre_rd_ff : sub_rd_ff) : '0;

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (mode_ff == MODE_READ) begin
            rsp_is_hit         <= 1'b0;
            rsp_is_prefix_rank <= 1'b0;
            rsp_slot_valid     <= rd_valid_ff;
            rsp_hit_category   <= rd_entry[ENTRY_W-1:NUM_W];
            rsp_hit_number     <= rd_entry[NUM_W-1:0];
         end else begin
            rsp_is_hit         <= fin_hit_ff;
            rsp_is_prefix_rank <= fin_pre_ff;
            rsp_slot_valid     <= 1'b0;
            rsp_hit_category   <= '0;
            rsp_hit_number     <= '0;
         end
         rsp_shown_count <= shown_w[SHOWN_W-1:0];
         rsp_total_hits  <= total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.mode     = mode_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

>>> rtl/ranked_substring_search.sv
// Ranked substring search. Program the query (up to 16 folded characters and a
// length; zero length matches nothing) over the APB-style port while idle, then
// stream each entry as name-byte and sort-key-byte transactions and end it with a
// finish transaction carrying category and number; the finish answers hit and
// rank, and a read transaction returns one slot of the merged list, prefix hits
// first. Clear scan empties both lists and the total. Transactions are handled
// one at a time by a three-state controller: name, key, clear and unused modes
// are taken and executed; finish and read are taken, executed, then load the
// output register, which holds the list memory read for a read, and wait while
// the output register stays stalled. The hit lists are 256-entry memories with
// no clearing pass; their counts mark which entries are live.
`default_nettype none

module ranked_substring_search
   import rss_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic [BYTE_W-1:0]  req_text_byte,
   input  wire logic [CAT_W-1:0]   req_entry_category,
   input  wire logic [NUM_W-1:0]   req_entry_number,
   input  wire logic [SLOT_W-1:0]  req_read_slot,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_is_hit,
   output logic                    rsp_is_prefix_rank,
   output logic                    rsp_slot_valid,
   output logic [CAT_W-1:0]        rsp_hit_category,
   output logic [NUM_W-1:0]        rsp_hit_number,
   output logic [SHOWN_W-1:0]      rsp_shown_count,
   output logic [TOTAL_W-1:0]      rsp_total_hits,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0]      prdata,
   output logic                    pready
);

   logic [PDATA_W-1:0] qlow_ff, qlow_in;
   logic [PDATA_W-1:0] qhigh_ff, qhigh_in;
   logic [QLEN_W-1:0]  qlen_ff, qlen_in;
   logic               csr_write;
   rss_cmd_type        cmd;
   rss_status_type     status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Decode configuration writes
   always_comb begin
      qlow_in  = qlow_ff;
      qhigh_in = qhigh_ff;
      qlen_in  = qlen_ff;
      if (csr_write) begin
         unique case (paddr[4:3])
            REG_QUERY_LOW:    qlow_in  = pwdata;
            REG_QUERY_HIGH:   qhigh_in = pwdata;
            REG_QUERY_LENGTH: qlen_in  = pwdata[QLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlow_ff  <= '0;
         qhigh_ff <= '0;
         qlen_ff  <= '0;
      end else begin
         qlow_ff  <= qlow_in;
         qhigh_ff <= qhigh_in;
         qlen_ff  <= qlen_in;
      end
   end

   // Return register contents
   always_comb begin
      unique case (paddr[4:3])
         REG_QUERY_LOW:    prdata = qlow_ff;
         REG_QUERY_HIGH:   prdata = qhigh_ff;
         REG_QUERY_LENGTH: prdata = PDATA_W'(qlen_ff);
         default:          prdata = '0;
      endcase
   end

   rss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rss_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_text_byte      (req_text_byte),
      .req_entry_category (req_entry_category),
      .req_entry_number   (req_entry_number),
      .req_read_slot      (req_read_slot),
      .query_bytes        ({qhigh_ff, qlow_ff}),
      .query_length       (qlen_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_hit         (rsp_is_hit),
      .rsp_is_prefix_rank (rsp_is_prefix_rank),
      .rsp_slot_valid     (rsp_slot_valid),
      .rsp_hit_category   (rsp_hit_category),
      .rsp_hit_number     (rsp_hit_number),
      .rsp_shown_count    (rsp_shown_count),
      .rsp_total_hits     (rsp_total_hits)
   );

endmodule

`default_nettype wire

>>> rtl/rss_checker.sv
`default_nettype none

module rss_checker
   import rss_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_is_hit,
   input wire logic               rsp_is_prefix_rank,
   input wire logic               rsp_slot_valid,
   input wire logic [CAT_W-1:0]   rsp_hit_category,
   input wire logic [NUM_W-1:0]   rsp_hit_number,
   input wire logic [SHOWN_W-1:0] rsp_shown_count,
   input wire logic [TOTAL_W-1:0] rsp_total_hits
);

   // Hold a stalled transaction unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_number) &&
         $stable(rsp_total_hits) && $stable(rsp_shown_count) && $stable(rsp_is_hit))
      else $error("stalled result changed");

   // One transaction at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a transaction while busy");

   // Prefix rank only on a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prefix_rank |-> rsp_is_hit)
      else $error("prefix rank without hit");

   // An invalid slot carries no entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_slot_valid |-> rsp_hit_category == '0 && rsp_hit_number == '0)
      else $error("entry data on invalid slot");

   // Shown count never exceeds the cap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shown_count <= SHOWN_W'(HIT_CAP))
      else $error("shown count above cap");

endmodule

bind ranked_substring_search rss_checker u_rss_checker (.*);

`default_nettype wire
